>>> hw/rtl/ede_pkg.sv
package ede_pkg;

    // Operation codes carried in the low bits of the input beat.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_FIRST  = 2'd1,
        OP_SECOND = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_SWEEP
    } seq_state_t;

    // Control that the sequencer hands to the column store each cycle.
    typedef struct packed {
        logic rd_en;
        logic col_we;
        logic str_we;
    } store_ctrl_t;

    localparam int OP_W        = 2;
    localparam int CH_W        = 8;
    localparam int DIST_W      = 7;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;
    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

endpackage

>>> hw/rtl/ede_update_unit.sv
module ede_update_unit #(
    parameter int CW = 7
) (
    input  logic [CW-1:0]           old_cost,
    input  logic [CW-1:0]           above_cost,
    input  logic [CW-1:0]           diag_cost,
    input  logic [ede_pkg::CH_W-1:0] byte_a,
    input  logic [ede_pkg::CH_W-1:0] byte_b,
    output logic [CW-1:0]           new_cost
);

    logic [CW:0] del_cost;
    logic [CW:0] ins_cost;
    logic [CW:0] sub_cost;
    logic [CW:0] min_ab;
    logic [CW:0] min_all;

    // Unit costs for deletion, insertion and substitution.
    assign del_cost = {1'b0, old_cost} + (CW+1)'(1);
    assign ins_cost = {1'b0, above_cost} + (CW+1)'(1);
    assign sub_cost = {1'b0, diag_cost} + (CW+1)'(byte_a != byte_b);

    // Minimum of the three; the result never exceeds the stored range.
    assign min_ab   = (del_cost < ins_cost) ? del_cost : ins_cost;
    assign min_all  = (min_ab < sub_cost) ? min_ab : sub_cost;
    assign new_cost = min_all[CW-1:0];

endmodule

>>> hw/rtl/ede_store.sv
module ede_store #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                      clk,
    input  ede_pkg::store_ctrl_t      ctrl,
    input  logic [AW-1:0]             wr_addr,
    input  logic [CW-1:0]             wr_cost,
    input  logic [ede_pkg::CH_W-1:0]  wr_byte,
    input  logic [AW-1:0]             rd_addr,
    output logic [CW-1:0]             rd_cost,
    output logic [ede_pkg::CH_W-1:0]  rd_byte
);

    logic [CW-1:0]            col_mem [MAX_LEN];
    logic [ede_pkg::CH_W-1:0] str_mem [MAX_LEN];
    logic [CW-1:0]            rd_cost_reg;
    logic [ede_pkg::CH_W-1:0] rd_byte_reg;

    // Cost column: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.col_we)
        begin
            col_mem[wr_addr] <= wr_cost;
        end
        if (ctrl.rd_en)
        begin
            rd_cost_reg <= col_mem[rd_addr];
        end
    end

    // First-string bytes, addressed in step with the column.
    always_ff @(posedge clk)
    begin
        if (ctrl.str_we)
        begin
            str_mem[wr_addr] <= wr_byte;
        end
        if (ctrl.rd_en)
        begin
            rd_byte_reg <= str_mem[rd_addr];
        end
    end

    assign rd_cost = rd_cost_reg;
    assign rd_byte = rd_byte_reg;

endmodule

>>> hw/rtl/edit_distance_engine.sv
// Levenshtein distance engine for two byte strings of up to MAX_LEN bytes each. Each input beat
// carries an operation and a byte: clear, append a first-string byte, take a second-string byte,
// or finish, which returns one beat with the distance and a sticky flag that is set when a byte
// was dropped since the last clear (a string was full, or a first-string byte came after the
// second string had started). A second-string byte sweeps the first_len entries of the stored
// cost column one entry per cycle through a single min-of-three update unit, reading the next
// entry from the column memory while the current one is written back. The input stays not
// ready during the sweep, and any input beat waits while an earlier result is still unread on
// the output.
module edit_distance_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] op, [9:2] ch, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [6:0] distance, [7] overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = LW;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = (CW > ede_pkg::DIST_W) ? CW : ede_pkg::DIST_W;

    ede_pkg::seq_state_t state_reg, state_next;
    logic [LW-1:0] first_len_reg, first_len_next;
    logic [LW-1:0] second_len_reg, second_len_next;
    logic          started_reg, started_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] last_cost_reg, last_cost_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] diag_reg, diag_next;
    logic [CW-1:0] above_reg, above_next;
    logic [ede_pkg::CH_W-1:0] ch_reg, ch_next;
    logic          out_valid_reg, out_valid_next;
    logic [ede_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    ede_pkg::store_ctrl_t     store_ctrl;
    logic [AW-1:0]            wr_addr;
    logic [CW-1:0]            wr_cost;
    logic [AW-1:0]            rd_addr;
    logic [CW-1:0]            rd_cost;
    logic [ede_pkg::CH_W-1:0] rd_byte;
    logic [CW-1:0]            new_cost;

    ede_pkg::op_t             in_op;
    logic [ede_pkg::CH_W-1:0] in_ch;
    logic                     accept;
    logic [LW-1:0]            first_len_inc;
    logic [LW-1:0]            second_len_inc;
    logic [CW-1:0]            final_cost;
    logic [SW-1:0]            final_ext;
    logic [ede_pkg::DIST_W-1:0] distance;

    // Input fields and handshake.
    assign in_op    = ede_pkg::op_t'(s_tdata[1:0]);
    assign in_ch    = s_tdata[9:2];
    assign s_tready = (state_reg == ede_pkg::SEQ_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign first_len_inc  = first_len_reg + LW'(1);
    assign second_len_inc = second_len_reg + LW'(1);

    // Distance: an empty first string gives the second-string length (the left edge).
    assign final_cost = (first_len_reg == '0) ? CW'(second_len_reg) : last_cost_reg;
    assign final_ext  = SW'(final_cost);
    assign distance   = (final_ext > SW'(ede_pkg::DIST_MAX)) ? ede_pkg::DIST_MAX
                                                              : final_ext[ede_pkg::DIST_W-1:0];

    ede_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .CW      (CW)
    ) u_store (
        .clk     (clk),
        .ctrl    (store_ctrl),
        .wr_addr (wr_addr),
        .wr_cost (wr_cost),
        .wr_byte (in_ch),
        .rd_addr (rd_addr),
        .rd_cost (rd_cost),
        .rd_byte (rd_byte)
    );

    ede_update_unit #(
        .CW (CW)
    ) u_update (
        .old_cost   (rd_cost),
        .above_cost (above_reg),
        .diag_cost  (diag_reg),
        .byte_a     (rd_byte),
        .byte_b     (ch_reg),
        .new_cost   (new_cost)
    );

    // Sequencer state and string bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ede_pkg::SEQ_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            started_reg    <= 1'b0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            started_reg    <= started_next;
            dropped_reg    <= dropped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Sweep working registers and the output payload.
    always_ff @(posedge clk)
    begin
        last_cost_reg <= last_cost_next;
        idx_reg       <= idx_next;
        diag_reg      <= diag_next;
        above_reg     <= above_next;
        ch_reg        <= ch_next;
        out_data_reg  <= out_data_next;
    end

    // Next state, store control and results.
    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        started_next    = started_reg;
        dropped_next    = dropped_reg;
        last_cost_next  = last_cost_reg;
        idx_next        = idx_reg;
        diag_next       = diag_reg;
        above_next      = above_reg;
        ch_next         = ch_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        store_ctrl      = '0;
        wr_addr         = first_len_reg[AW-1:0];
        wr_cost         = CW'(first_len_inc);
        rd_addr         = '0;

        unique case (state_reg)
            ede_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        ede_pkg::OP_CLEAR:
                        begin
                            first_len_next  = '0;
                            second_len_next = '0;
                            started_next    = 1'b0;
                            dropped_next    = 1'b0;
                        end
                        ede_pkg::OP_FIRST:
                        begin
                            if (started_reg || (first_len_reg == LW'(MAX_LEN)))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                store_ctrl.col_we = 1'b1;
                                store_ctrl.str_we = 1'b1;
                                last_cost_next    = CW'(first_len_inc);
                                first_len_next    = first_len_inc;
                            end
                        end
                        ede_pkg::OP_SECOND:
                        begin
                            if (second_len_reg == LW'(MAX_LEN))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                started_next    = 1'b1;
                                diag_next       = CW'(second_len_reg);
                                above_next      = CW'(second_len_inc);
                                second_len_next = second_len_inc;
                                ch_next         = in_ch;
                                if (first_len_reg != '0)
                                begin
                                    store_ctrl.rd_en = 1'b1;
                                    rd_addr          = '0;
                                    idx_next         = '0;
                                    state_next       = ede_pkg::SEQ_SWEEP;
                                end
                            end
                        end
                        ede_pkg::OP_FINISH:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {dropped_reg, distance};
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            ede_pkg::SEQ_SWEEP:
            begin
                // Write back entry idx and fetch the next one in the same cycle.
                store_ctrl.col_we = 1'b1;
                wr_addr           = idx_reg;
                wr_cost           = new_cost;
                diag_next         = rd_cost;
                above_next        = new_cost;
                if ((LW'(idx_reg) + LW'(1)) == first_len_reg)
                begin
                    last_cost_next = new_cost;
                    state_next     = ede_pkg::SEQ_IDLE;
                end
                else
                begin
                    store_ctrl.rd_en = 1'b1;
                    rd_addr          = idx_reg + AW'(1);
                    idx_next         = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ede_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // No input beat is taken while the column sweep runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ede_pkg::SEQ_SWEEP) |-> !s_tready)
    else $error("input accepted during column sweep");

    // The sweep index stays inside the stored first string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ede_pkg::SEQ_SWEEP) |-> (LW'(idx_reg) < first_len_reg))
    else $error("sweep index beyond first string");

    // String lengths never pass the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LW'(MAX_LEN)) && (second_len_reg <= LW'(MAX_LEN)))
    else $error("string length beyond limit");

    // An accepted finish presents a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == ede_pkg::OP_FINISH)) |=> m_tvalid)
    else $error("finish without result");

    // A second-string byte that is kept marks the second string as started.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == ede_pkg::OP_SECOND) && (second_len_reg != LW'(MAX_LEN)))
        |=> started_reg)
    else $error("second string not marked as started");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_LEN    = 64;
    localparam int N_ITEMS    = 1350;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AT    = 25;
    localparam int TAIL_WAIT  = 2 * (MAX_LEN + 1);
    localparam int MAX_REPORT = 10;

    // One pending input beat; a drain beat is held back until no distance is outstanding.
    typedef struct {
        ede_pkg::op_t op;
        logic [7:0]   ch;
        bit           drain;
    } req_t;

    // One expected result beat.
    typedef struct {
        logic [ede_pkg::DIST_W-1:0] distance;
        logic                       overflow;
    } dist_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [1:0] op, [9:2] ch, [15:10] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [6:0] distance, [7] overflow

    req_t  beat_q[$];
    dist_t dist_expect_q[$];
    req_t  tx_cur;
    int    tx_gap;
    int    tx_sent;
    int    rx_wait;
    int    rx_next;
    int    rx_results;
    int    mismatches;
    int    item_cnt;
    int    op_cnt[4];
    int    max_dist;
    int    ovf_seen;

    // Shadow copy of the engine state.
    logic [7:0] str_mem[MAX_LEN];
    int         cost_mem[MAX_LEN];
    int         left_col;
    int         first_len;
    int         second_len;
    bit         second_started;
    bit         dropped;

    edit_distance_engine #(
        .MAX_LEN (MAX_LEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Reports a failure; only the first few are printed in full.
    task automatic note_mismatch(input string msg);
        begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
                $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    // Advances the shadow state by one accepted beat and queues any distance it yields.
    task automatic levenshtein_step(input ede_pkg::op_t op, input logic [7:0] ch);
        int    diag;
        int    above;
        int    prev;
        int    sub;
        int    v;
        int    d;
        dist_t res;
        begin
            op_cnt[op]++;
            case (op)
                ede_pkg::OP_CLEAR:
                begin
                    left_col       = 0;
                    first_len      = 0;
                    second_len     = 0;
                    second_started = 1'b0;
                    dropped        = 1'b0;
                end
                ede_pkg::OP_FIRST:
                begin
                    if (second_started || first_len >= MAX_LEN)
                        dropped = 1'b1;
                    else
                    begin
                        str_mem[first_len]  = ch;
                        cost_mem[first_len] = first_len + 1;
                        first_len++;
                    end
                end
                ede_pkg::OP_SECOND:
                begin
                    if (second_len >= MAX_LEN)
                        dropped = 1'b1;
                    else
                    begin
                        second_started = 1'b1;
                        diag = second_len;
                        second_len++;
                        left_col = second_len;
                        above = left_col;
                        // Sweep the column: min of deletion, insertion and substitution.
                        for (int k = 0; k < first_len; k++)
                        begin
                            prev = cost_mem[k];
                            sub  = diag + ((str_mem[k] == ch) ? 0 : 1);
                            v    = prev + 1;
                            if (above + 1 < v)
                                v = above + 1;
                            if (sub < v)
                                v = sub;
                            cost_mem[k] = v;
                            above = v;
                            diag = prev;
                        end
                    end
                end
                default:
                begin
                    d = (first_len == 0) ? left_col : cost_mem[first_len - 1];
                    if (d > int'(ede_pkg::DIST_MAX))
                        d = int'(ede_pkg::DIST_MAX);
                    res.distance = d[ede_pkg::DIST_W-1:0];
                    res.overflow = dropped;
                    dist_expect_q.push_back(res);
                end
            endcase
        end
    endtask

    // Sender: one beat per handshake, random gaps, 64-beat stretches without gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= 0;
            tx_sent  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                levenshtein_step(tx_cur.op, tx_cur.ch);
            if (s_tvalid && !s_tready)
            begin
                // Beat still offered; hold it.
            end
            else if (tx_gap > 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (beat_q.size() > 0 && (!beat_q[0].drain || dist_expect_q.size() == 0))
            begin
                tx_cur = beat_q.pop_front();
                s_tdata  <= {6'b0, tx_cur.ch, tx_cur.op};
                s_tvalid <= 1'b1;
                tx_gap   <= tx_sent[6] ? 0 : $urandom_range(0, 3);
                tx_sent  <= tx_sent + 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: checks each result beat, stalls at random and once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            rx_wait    <= 0;
            rx_results <= 0;
        end
        else
        begin
            rx_next = rx_wait;
            if (m_tvalid && m_tready)
            begin
                if (dist_expect_q.size() == 0)
                    note_mismatch($sformatf("unexpected result beat 0x%02h", m_tdata));
                else
                begin
                    dist_t e;
                    e = dist_expect_q.pop_front();
                    if (m_tdata[6:0] !== e.distance)
                        note_mismatch($sformatf("distance expected %0d, got %0d",
                                                e.distance, m_tdata[6:0]));
                    if (m_tdata[7] !== e.overflow)
                        note_mismatch($sformatf("overflow expected %0b, got %0b",
                                                e.overflow, m_tdata[7]));
                    if (int'(e.distance) > max_dist)
                        max_dist = int'(e.distance);
                    if (e.overflow)
                        ovf_seen++;
                end
                rx_results <= rx_results + 1;
                if (rx_results + 1 == HOLD_AT)
                    rx_next = LONG_HOLD;
                else
                    rx_next = rx_results[5] ? 0 : $urandom_range(0, 3);
            end
            else if (rx_next > 0)
                rx_next = rx_next - 1;
            rx_wait  <= rx_next;
            m_tready <= (rx_next == 0);
        end
    end

    task automatic push_beat(input ede_pkg::op_t op, input logic [7:0] ch, input bit drain);
        req_t r;
        begin
            r.op    = op;
            r.ch    = ch;
            r.drain = drain;
            beat_q.push_back(r);
            item_cnt++;
        end
    endtask

    function automatic logic [7:0] pick_char(input bit narrow, input logic [7:0] base);
        pick_char = narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom);
    endfunction

    // A clear, a first string, a second string, an optional late first-string byte and one or two finishes.
    task automatic push_pair(input int len_a, input int len_b, input bit drain,
                             input bit late_byte);
        bit         narrow;
        logic [7:0] base;
        begin
            narrow = 1'($urandom_range(0, 1));
            base   = 8'($urandom);
            push_beat(ede_pkg::OP_CLEAR, 8'($urandom), drain);
            for (int i = 0; i < len_a; i++)
                push_beat(ede_pkg::OP_FIRST, pick_char(narrow, base), 1'b0);
            for (int i = 0; i < len_b; i++)
                push_beat(ede_pkg::OP_SECOND, pick_char(narrow, base), 1'b0);
            if (late_byte)
                push_beat(ede_pkg::OP_FIRST, pick_char(narrow, base), 1'b0);
            push_beat(ede_pkg::OP_FINISH, 8'($urandom), 1'b0);
            if ($urandom_range(0, 4) == 0)
                push_beat(ede_pkg::OP_FINISH, 8'($urandom), 1'b0);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        int kind;
        int len_a;
        int len_b;

        mismatches = 0;
        item_cnt   = 0;
        max_dist   = 0;
        ovf_seen   = 0;
        op_cnt     = '{default: 0};

        // Directed: empty pair, extreme bytes, repeated finish, late first byte,
        // empty first string, ignored bytes on clear and finish.
        push_beat(ede_pkg::OP_CLEAR,  8'hA5, 1'b0);
        push_beat(ede_pkg::OP_FINISH, 8'h5A, 1'b0);
        push_beat(ede_pkg::OP_FIRST,  8'h00, 1'b0);
        push_beat(ede_pkg::OP_FIRST,  8'hFF, 1'b0);
        push_beat(ede_pkg::OP_SECOND, 8'hFF, 1'b0);
        push_beat(ede_pkg::OP_SECOND, 8'h00, 1'b0);
        push_beat(ede_pkg::OP_FINISH, 8'hFF, 1'b0);
        push_beat(ede_pkg::OP_FINISH, 8'h00, 1'b0);
        push_beat(ede_pkg::OP_FIRST,  8'h12, 1'b0);
        push_beat(ede_pkg::OP_FINISH, 8'h00, 1'b0);
        push_beat(ede_pkg::OP_CLEAR,  8'hFF, 1'b0);
        push_beat(ede_pkg::OP_SECOND, 8'h41, 1'b0);
        push_beat(ede_pkg::OP_SECOND, 8'h42, 1'b0);
        push_beat(ede_pkg::OP_FINISH, 8'h00, 1'b0);
        push_beat(ede_pkg::OP_CLEAR,  8'h00, 1'b0);
        push_beat(ede_pkg::OP_FIRST,  8'h80, 1'b0);
        push_beat(ede_pkg::OP_FINISH, 8'h7F, 1'b0);

        // Both strings overfilled, after a pause for all outstanding results.
        push_pair(MAX_LEN + 2, MAX_LEN + 2, 1'b1, 1'b0);

        // Random: mostly well-formed pairs, rarely at full length, plus some noise.
        while (item_cnt < N_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 85)
            begin
                len_a = ($urandom_range(0, 29) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 3)
                                                     : $urandom_range(0, 8);
                len_b = ($urandom_range(0, 29) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 3)
                                                     : $urandom_range(0, 8);
                push_pair(len_a, len_b, $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_beat(ede_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), 1'b0);
            end
        end
        push_beat(ede_pkg::OP_FINISH, 8'h00, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (dist_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d beats (clear %0d, first %0d, second %0d, finish %0d).",
                 tx_sent, op_cnt[ede_pkg::OP_CLEAR], op_cnt[ede_pkg::OP_FIRST],
                 op_cnt[ede_pkg::OP_SECOND], op_cnt[ede_pkg::OP_FINISH]);
        $display("Checked %0d distances, largest %0d, %0d with bytes dropped; %0d mismatches.",
                 rx_results, max_dist, ovf_seen, mismatches);
        if (mismatches == 0)
            $display("PASS edit_distance_engine");
        else
            $display("FAIL edit_distance_engine");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #5000000;
        $display("Timeout with %0d beats queued and %0d results outstanding.",
                 beat_q.size(), dist_expect_q.size());
        $display("FAIL edit_distance_engine");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ede_pkg.sv
hw/rtl/ede_update_unit.sv
hw/rtl/ede_store.sv
hw/rtl/edit_distance_engine.sv
tb/testbench.sv
